### design/stxc_pkg.sv
// Package with the item types, byte codes and status codes of the STX/ETX escape codec.
`timescale 1ns / 1ps

package stxc_pkg;

	// Framing and escape byte values.
	localparam logic [7:0] STX_BYTE = 8'h02;
	localparam logic [7:0] ETX_BYTE = 8'h03;
	localparam logic [7:0] ESC_BYTE = 8'h1B;
	localparam logic [7:0] STX_SUB  = 8'hE7;
	localparam logic [7:0] ETX_SUB  = 8'hE8;
	localparam logic [7:0] ESC_SUB  = 8'h00;

	// Shortest acceptable frame, counted in raw bytes.
	localparam logic [3:0] MIN_FRAME = 4'd8;
	localparam logic [3:0] CNT_MAX   = 4'd15;

	// Frame status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SHORT     = 2'd1;
	localparam logic [1:0] ST_BAD_DELIM = 2'd2;
	localparam logic [1:0] ST_FORBIDDEN = 2'd3;

	// Direction register values.
	localparam logic DIR_DECODE = 1'b0;
	localparam logic DIR_ENCODE = 1'b1;

	// One raw input item.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_first;
		logic       in_last;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       frame_end;
		logic [1:0] status;
		logic       run_last;
	} out_item_t;

	// Decoder answer for the item it is shown.
	typedef struct packed {
		logic      emit;
		out_item_t res;
	} dec_res_t;

	// True when a byte has to be escaped on the encode side.
	function automatic logic needs_escape(input logic [7:0] b);
		return (b == STX_BYTE) || (b == ETX_BYTE) || (b == ESC_BYTE);
	endfunction

	// Second byte of an escape pair.
	function automatic logic [7:0] escape_sub(input logic [7:0] b);
		logic [7:0] s;
		unique case (b)
			STX_BYTE: s = STX_SUB;
			ETX_BYTE: s = ETX_SUB;
			default:  s = ESC_SUB;
		endcase
		return s;
	endfunction

endpackage

### design/stxc_frame_decoder.sv
// Frame decoder: holds the per-frame state and works out the result of one received byte.
`timescale 1ns / 1ps

module stxc_frame_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  stxc_pkg::in_item_t item,
	input  logic              commit,
	output stxc_pkg::dec_res_t dec
);
	import stxc_pkg::*;

	logic       esc_pending_q;
	logic [3:0] raw_count_q;
	logic       delim_bad_q;
	logic       forbid_seen_q;

	logic       esc_nx;
	logic [3:0] cnt_nx;
	logic       dbad_nx;
	logic       fseen_nx;

	logic       esc0;
	logic [3:0] cnt0;
	logic [3:0] cnt1;
	logic       dbad0;
	logic       fseen0;
	logic       dbad_end;
	logic       fseen_mid;

	// Per-frame state as seen by this byte, and the decode decision.
	always_comb begin
		esc0   = item.in_first ? 1'b0 : esc_pending_q;
		cnt0   = item.in_first ? 4'd0 : raw_count_q;
		dbad0  = item.in_first ? 1'b0 : delim_bad_q;
		fseen0 = item.in_first ? 1'b0 : forbid_seen_q;
		cnt1   = (cnt0 < CNT_MAX) ? cnt0 + 4'd1 : cnt0;

		dbad_end  = dbad0 || (item.in_first && item.in_byte != STX_BYTE) ||
			(item.in_byte != ETX_BYTE);
		fseen_mid = fseen0 || (item.in_byte == STX_BYTE) || (item.in_byte == ETX_BYTE);

		dec = '0;
		dec.res.run_last = 1'b1;
		esc_nx   = esc0;
		cnt_nx   = cnt1;
		dbad_nx  = dbad0;
		fseen_nx = fseen0;

		if (item.in_last) begin
			// Closing byte: give the status and clear the frame state.
			dec.emit          = 1'b1;
			dec.res.frame_end = 1'b1;
			if (cnt1 < MIN_FRAME) begin
				dec.res.status = ST_SHORT;
			end else if (dbad_end) begin
				dec.res.status = ST_BAD_DELIM;
			end else if (fseen0) begin
				dec.res.status = ST_FORBIDDEN;
			end else begin
				dec.res.status     = ST_OK;
				dec.res.out_byte   = ETX_BYTE;
				dec.res.byte_valid = 1'b1;
			end
			esc_nx   = 1'b0;
			cnt_nx   = 4'd0;
			dbad_nx  = 1'b0;
			fseen_nx = 1'b0;
		end else if (item.in_first) begin
			// Opening byte: pass a start delimiter, flag anything else.
			if (item.in_byte == STX_BYTE) begin
				dec.emit           = 1'b1;
				dec.res.out_byte   = STX_BYTE;
				dec.res.byte_valid = 1'b1;
			end else begin
				dbad_nx = 1'b1;
			end
		end else begin
			// Interior byte: check, unescape and pass on.
			fseen_nx = fseen_mid;
			if (dbad0 || fseen_mid) begin
				dec.emit = 1'b0;
			end else if (item.in_byte == ESC_BYTE) begin
				esc_nx = 1'b1;
			end else begin
				dec.emit           = 1'b1;
				dec.res.out_byte   = esc0 ? item.in_byte + ESC_BYTE : item.in_byte;
				dec.res.byte_valid = 1'b1;
				esc_nx             = 1'b0;
			end
		end
	end

	// State moves only when the item retires in decode mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pending_q <= 1'b0;
			raw_count_q   <= 4'd0;
			delim_bad_q   <= 1'b0;
			forbid_seen_q <= 1'b0;
		end else if (commit) begin
			esc_pending_q <= esc_nx;
			raw_count_q   <= cnt_nx;
			delim_bad_q   <= dbad_nx;
			forbid_seen_q <= fseen_nx;
		end
	end

`ifndef SYNTHESIS
	// A committed closing byte leaves a clean frame state.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && item.in_last) |=> (raw_count_q == 4'd0 && !esc_pending_q &&
			!delim_bad_q && !forbid_seen_q))
		else $error("frame state not cleared after last byte");
`endif

endmodule

### design/stx_etx_escape_codec.sv
// Top level of the STX/ETX escape codec: input register, encoder, decoder and result register.
`timescale 1ns / 1ps

// The codec takes one raw byte per cycle on raw_valid/raw_stall, except while raw_stall holds it off, and
// gives its results on res_valid/res_stall. With cfg_wdata written as 1 it encodes: 0x02, 0x03 and 0x1B
// become 0x1B followed by 0xE7, 0xE8 or 0x00, and other bytes pass through. Written as 0 it decodes
// whole frames and reports a status on the closing byte. An encode byte that needs escaping holds the
// input register until both of its results are loaded into the result register, because the single
// result register sends one result per cycle; decoder items that produce no result retire at once.
// An accepted byte is held in the input register and its result is then loaded into the result register;
// res_stall can hold it in between. Write the direction only while no items are in flight.
module stx_etx_escape_codec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                raw_valid,
	output logic                raw_stall,
	input  stxc_pkg::in_item_t  raw_item,
	output logic                res_valid,
	input  logic                res_stall,
	output stxc_pkg::out_item_t res_item,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import stxc_pkg::*;

	logic      direction_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      phase_q;
	logic      res_valid_q;
	out_item_t res_q;

	dec_res_t  dec;
	out_item_t enc_r0;
	out_item_t enc_r1;
	out_item_t sel_res;
	logic      has_res;
	logic      two_res;
	logic      slot_free;
	logic      load_out;
	logic      retire;
	logic      raw_accept;

	// Direction register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_DECODE;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
		end
	end

	stxc_frame_decoder u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.commit (retire && direction_q == DIR_DECODE),
		.dec    (dec)
	);

	// Encoder results: a plain byte, or an escape pair.
	always_comb begin
		enc_r0 = '0;
		enc_r1 = '0;
		enc_r0.byte_valid = 1'b1;
		enc_r1.byte_valid = 1'b1;
		enc_r1.out_byte   = escape_sub(item_s1.in_byte);
		enc_r1.frame_end  = item_s1.in_last;
		enc_r1.run_last   = 1'b1;
		if (needs_escape(item_s1.in_byte)) begin
			enc_r0.out_byte = ESC_BYTE;
		end else begin
			enc_r0.out_byte  = item_s1.in_byte;
			enc_r0.frame_end = item_s1.in_last;
			enc_r0.run_last  = 1'b1;
		end
	end

	// Result selection and the item flow control.
	always_comb begin
		if (direction_q == DIR_ENCODE) begin
			has_res = 1'b1;
			two_res = needs_escape(item_s1.in_byte);
			sel_res = phase_q ? enc_r1 : enc_r0;
		end else begin
			has_res = dec.emit;
			two_res = 1'b0;
			sel_res = dec.res;
		end
		slot_free  = !res_valid_q || !res_stall;
		load_out   = valid_s1 && has_res && slot_free;
		retire     = valid_s1 && (!has_res || (slot_free && (!two_res || phase_q)));
		raw_stall  = valid_s1 && !retire;
		raw_accept = raw_valid && !raw_stall;
	end

	// Input register and escape-pair phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (raw_accept) begin
				valid_s1 <= 1'b1;
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
			if (retire) begin
				phase_q <= 1'b0;
			end else if (load_out && two_res) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (raw_accept) begin
			item_s1 <= raw_item;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (slot_free) begin
			res_valid_q <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q <= sel_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

`ifndef SYNTHESIS
	// The second half of an escape pair only exists with an item held.
	a_phase_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> valid_s1)
		else $error("escape phase set without an item");

	// A result that is not the last of its item is followed by the second half.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !sel_res.run_last) |=> phase_q)
		else $error("escape pair broken");

	// An empty input register never holds off the source.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !raw_stall)
		else $error("stall with empty input register");

	// A failed status closes the frame and carries no byte.
	a_bad_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.status != ST_OK) |-> (res_item.frame_end && !res_item.byte_valid))
		else $error("bad status on a data result");
`endif

endmodule
